>>> rtl/core/spg_pkg.sv
// Package for the shape pixel generator: widths, shape codes, palette and
// the quarter-wave Q1.16 cosine table. No dependencies.
`default_nettype none
package spg_pkg;

  localparam int unsigned MaxDimDef   = 4096;
  localparam int unsigned AngleSteps  = 360;
  localparam int unsigned CoordW      = 14;
  localparam int unsigned SizeW       = 12;
  localparam int unsigned AddrW       = 26;
  localparam int unsigned TrigW       = 18;   // signed Q2.16

  typedef enum logic [2:0] {
    KindPlus    = 3'd0,
    KindOutline = 3'd1,
    KindFilled  = 3'd2,
    KindCircle  = 3'd3,
    KindEllipse = 3'd4
  } shape_kind_e;

  localparam logic [1:0] RegHeight = 2'd0;
  localparam logic [1:0] RegWidth  = 2'd1;
  localparam logic [1:0] RegChans  = 2'd2;
  localparam logic [1:0] RegColor  = 2'd3;

  // palette entry as {c0, c1, c2}
  function automatic logic [23:0] palette(input logic [3:0] idx);
    logic [23:0] v;
    case (idx)
      4'd0: v = 24'h6495ed;
      4'd1: v = 24'h00ff00;
      4'd2: v = 24'hff4500;
      4'd3: v = 24'hffd700;
      4'd4: v = 24'hff00ff;
      4'd5: v = 24'hffdab9;
      4'd6: v = 24'h00008b;
      4'd7: v = 24'h006400;
      4'd8: v = 24'hb03060;
      default: v = 24'h00ffff;
    endcase
    return v;
  endfunction

  // cos(d degrees) for d = 0..90 in unsigned Q1.16; sin(d) = cos(90-d)
  function automatic logic [16:0] qcos(input logic [6:0] d);
    logic [16:0] v;
    case (d)
      7'd0: v = 17'd65536; 7'd1: v = 17'd65526; 7'd2: v = 17'd65496;
      7'd3: v = 17'd65446; 7'd4: v = 17'd65376; 7'd5: v = 17'd65287;
      7'd6: v = 17'd65177; 7'd7: v = 17'd65048; 7'd8: v = 17'd64898;
      7'd9: v = 17'd64729; 7'd10: v = 17'd64540; 7'd11: v = 17'd64332;
      7'd12: v = 17'd64104; 7'd13: v = 17'd63856; 7'd14: v = 17'd63589;
      7'd15: v = 17'd63303; 7'd16: v = 17'd62997; 7'd17: v = 17'd62672;
      7'd18: v = 17'd62328; 7'd19: v = 17'd61966; 7'd20: v = 17'd61584;
      7'd21: v = 17'd61183; 7'd22: v = 17'd60764; 7'd23: v = 17'd60326;
      7'd24: v = 17'd59870; 7'd25: v = 17'd59396; 7'd26: v = 17'd58903;
      7'd27: v = 17'd58393; 7'd28: v = 17'd57865; 7'd29: v = 17'd57319;
      7'd30: v = 17'd56756; 7'd31: v = 17'd56175; 7'd32: v = 17'd55578;
      7'd33: v = 17'd54963; 7'd34: v = 17'd54332; 7'd35: v = 17'd53684;
      7'd36: v = 17'd53020; 7'd37: v = 17'd52339; 7'd38: v = 17'd51643;
      7'd39: v = 17'd50931; 7'd40: v = 17'd50203; 7'd41: v = 17'd49461;
      7'd42: v = 17'd48703; 7'd43: v = 17'd47930; 7'd44: v = 17'd47143;
      7'd45: v = 17'd46341; 7'd46: v = 17'd45525; 7'd47: v = 17'd44695;
      7'd48: v = 17'd43852; 7'd49: v = 17'd42995; 7'd50: v = 17'd42126;
      7'd51: v = 17'd41243; 7'd52: v = 17'd40348; 7'd53: v = 17'd39441;
      7'd54: v = 17'd38521; 7'd55: v = 17'd37590; 7'd56: v = 17'd36647;
      7'd57: v = 17'd35693; 7'd58: v = 17'd34729; 7'd59: v = 17'd33754;
      7'd60: v = 17'd32768; 7'd61: v = 17'd31772; 7'd62: v = 17'd30767;
      7'd63: v = 17'd29753; 7'd64: v = 17'd28729; 7'd65: v = 17'd27697;
      7'd66: v = 17'd26656; 7'd67: v = 17'd25607; 7'd68: v = 17'd24550;
      7'd69: v = 17'd23486; 7'd70: v = 17'd22415; 7'd71: v = 17'd21336;
      7'd72: v = 17'd20252; 7'd73: v = 17'd19161; 7'd74: v = 17'd18064;
      7'd75: v = 17'd16962; 7'd76: v = 17'd15855; 7'd77: v = 17'd14742;
      7'd78: v = 17'd13626; 7'd79: v = 17'd12505; 7'd80: v = 17'd11380;
      7'd81: v = 17'd10252; 7'd82: v = 17'd9121;  7'd83: v = 17'd7987;
      7'd84: v = 17'd6850;  7'd85: v = 17'd5712;  7'd86: v = 17'd4572;
      7'd87: v = 17'd3430;  7'd88: v = 17'd2287;  7'd89: v = 17'd1144;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/spg_trig.sv
// Signed Q2.16 cosine and sine of a whole-degree angle, by quadrant folding
// of the quarter-wave table. Depends on spg_pkg.
`default_nettype none
module spg_trig (
  input  logic [8:0]                           angle_i,
  output logic signed [spg_pkg::TrigW-1:0]     cos_o,
  output logic signed [spg_pkg::TrigW-1:0]     sin_o
);
  logic [1:0]  quad;
  logic [6:0]  rem;
  logic [16:0] c_mag;
  logic [16:0] s_mag;

  always_comb begin
    if (angle_i >= 9'd270) begin
      quad = 2'd3; rem = 7'(angle_i - 9'd270);
    end else if (angle_i >= 9'd180) begin
      quad = 2'd2; rem = 7'(angle_i - 9'd180);
    end else if (angle_i >= 9'd90) begin
      quad = 2'd1; rem = 7'(angle_i - 9'd90);
    end else begin
      quad = 2'd0; rem = angle_i[6:0];
    end
    c_mag = spg_pkg::qcos(rem);
    s_mag = spg_pkg::qcos(7'(7'd90 - rem));
    case (quad)
      2'd0: begin
        cos_o = $signed({1'b0, c_mag});  sin_o = $signed({1'b0, s_mag});
      end
      2'd1: begin
        cos_o = -$signed({1'b0, s_mag}); sin_o = $signed({1'b0, c_mag});
      end
      2'd2: begin
        cos_o = -$signed({1'b0, c_mag}); sin_o = -$signed({1'b0, s_mag});
      end
      default: begin
        cos_o = $signed({1'b0, s_mag});  sin_o = -$signed({1'b0, c_mag});
      end
    endcase
  end
endmodule
`default_nettype wire

>>> rtl/core/shape_pixel_generator.sv
// Shape pixel generator: top level with scan sequencer and shared multiplier.
// Depends on spg_pkg and spg_trig.
//
// A load request (op 0) latches a shape of a valid kind and gives no result.
// Each step request (op 1) then yields one candidate pixel with its clip flag,
// byte address, palette bytes and a last-pixel mark. A step on a plus or a
// rectangle passes through StClip and StAddr, on a circle or ellipse through
// StCol, StClip and StAddr: one 16x19 multiplier is shared for the circle
// row term, the column term, then row*width; channel scaling of the address
// parts is a small 2-bit product. The input is stalled while a step is in
// flight, and also while a finished result waits in the output register
// on a stalled output. No memory, no clearing pass.
`default_nettype none
module shape_pixel_generator #(
  parameter int unsigned MaxDim = spg_pkg::MaxDimDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [3:0]                          paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                op_i,
  input  logic [2:0]                          shape_kind_i,
  input  logic signed [spg_pkg::CoordW-1:0]   center_row_i,
  input  logic signed [spg_pkg::CoordW-1:0]   center_col_i,
  input  logic [spg_pkg::SizeW-1:0]           size_a_i,
  input  logic [spg_pkg::SizeW-1:0]           size_b_i,
  input  logic                                centered_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                write_valid_o,
  output logic                                done_res_o,
  output logic [11:0]                         pixel_row_o,
  output logic [11:0]                         pixel_col_o,
  output logic [spg_pkg::AddrW-1:0]           byte_address_o,
  output logic [7:0]                          chan0_o,
  output logic [7:0]                          chan1_o,
  output logic [7:0]                          chan2_o
);
  localparam int unsigned DimW = $clog2(MaxDim + 1);

  typedef enum logic [2:0] {
    StIdle, StCol, StClip, StAddr
  } state_e;

  // configuration
  logic [12:0] height_q, width_q;
  logic [1:0]  chans_q;
  logic [7:0]  color_q;
  logic        wr_en;
  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      height_q <= 13'd512; width_q <= 13'd512; chans_q <= 2'd3; color_q <= 8'd0;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        spg_pkg::RegHeight: height_q <= pwdata[12:0];
        spg_pkg::RegWidth:  width_q  <= pwdata[12:0];
        spg_pkg::RegChans:  chans_q  <= pwdata[1:0];
        default:            color_q  <= pwdata[7:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      spg_pkg::RegHeight: prdata = {19'd0, height_q};
      spg_pkg::RegWidth:  prdata = {19'd0, width_q};
      spg_pkg::RegChans:  prdata = {30'd0, chans_q};
      default:            prdata = {24'd0, color_q};
    endcase
  end

  // shape state
  state_e              state_q;
  logic [2:0]          kind_q;
  logic signed [13:0]  srow_q, scol_q;
  logic [12:0]         ext_a_q, ext_b_q;
  logic [13:0]         outer_q, inner_q;
  logic                phase_q, busy_q;
  // step working registers
  logic signed [15:0]  r_q, c_q;
  logic                last_q;
  logic [DimW-1:0]     h_lim, w_lim;
  logic [25:0]         rowbase_q;

  // shared multiplier: signed 16 x signed 19
  logic signed [15:0]  mul_a;
  logic signed [18:0]  mul_b;
  logic signed [34:0]  mul_p;
  assign mul_p = mul_a * mul_b;

  logic signed [spg_pkg::TrigW-1:0] cos_v, sin_v;
  logic [8:0] angle;
  assign angle = 9'(outer_q);
  spg_trig u_trig (.angle_i(angle), .cos_o(cos_v), .sin_o(sin_v));

  assign h_lim = (32'(height_q) > MaxDim) ? DimW'(MaxDim) : DimW'(height_q);
  assign w_lim = (32'(width_q)  > MaxDim) ? DimW'(MaxDim) : DimW'(width_q);

  // truncate toward zero of (p + base*65536)/65536
  function automatic logic signed [15:0] q16(input logic signed [34:0] p,
                                              input logic signed [13:0] base);
    logic signed [35:0] s;
    logic signed [35:0] adj;
    begin
      s   = 36'(p) + {{6{base[13]}}, base, 16'd0};
      adj = s[35] ? s + 36'sd65535 : s;
      return 16'(adj >>> 16);
    end
  endfunction

  // signed 16-bit views of the scan counters and extents
  logic signed [15:0] oi, ii, ea, eb;
  assign oi = $signed({2'b0, outer_q});
  assign ii = $signed({2'b0, inner_q});
  assign ea = $signed({3'b0, ext_a_q});
  assign eb = $signed({3'b0, ext_b_q});

  logic in_acc, clip_ok;
  assign in_acc = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != StIdle) || (out_valid_o && out_stall_i);
  assign clip_ok = !r_q[15] && !c_q[15] &&
                   (r_q < $signed({1'b0, 15'(h_lim)})) &&
                   (c_q < $signed({1'b0, 15'(w_lim)}));

  // load-time corner and extent adjustment
  logic signed [13:0] ld_row, ld_col;
  logic [12:0]        ld_a, ld_b;
  logic               kind_ok;
  always_comb begin
    ld_row = center_row_i; ld_col = center_col_i;
    ld_a = {1'b0, size_a_i}; ld_b = {1'b0, size_b_i};
    kind_ok = shape_kind_i <= 3'(spg_pkg::KindEllipse);
    case (shape_kind_i)
      3'(spg_pkg::KindOutline), 3'(spg_pkg::KindFilled): begin
        if (!centered_i) begin
          ld_row = center_row_i + 14'(size_a_i[11:1]) + 14'sd2;
          ld_col = center_col_i + 14'(size_b_i[11:1]) + 14'sd2;
          if (shape_kind_i == 3'(spg_pkg::KindOutline)) begin
            ld_a = 13'(size_a_i) + 13'd2; ld_b = 13'(size_b_i) + 13'd2;
          end
        end
        ld_a = ld_a >> 1; ld_b = ld_b >> 1;
      end
      3'(spg_pkg::KindPlus): begin
        ld_a = 13'(size_a_i[11:1]); ld_b = 13'd0;
      end
      3'(spg_pkg::KindCircle): ld_b = {1'b0, size_a_i};
      default: ;
    endcase
  end

  logic [25:0] col_term;
  assign col_term = 26'(c_q) * 26'(chans_q);

  // palette index: colour mod 10 by reciprocal multiply (exact below 1029)
  logic [15:0] color_prod;
  logic [4:0]  color_div;
  logic [3:0]  color_mod;
  logic [23:0] pal;
  assign color_prod = 16'(color_q) * 16'd205;
  assign color_div  = color_prod[15:11];
  assign color_mod  = 4'(color_q - 8'({color_div, 3'd0}) - 8'({color_div, 1'b0}));
  assign pal = spg_pkg::palette(color_mod);

  always_comb begin
    mul_a = 16'sd0; mul_b = 19'sd0;
    case (state_q)
      StIdle: begin mul_a = ea; mul_b = 19'(cos_v); end
      StCol:  begin mul_a = eb; mul_b = 19'(sin_v); end
      StClip: begin mul_a = r_q; mul_b = $signed({6'd0, 13'(w_lim)}); end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; kind_q <= 3'd0; srow_q <= '0; scol_q <= '0;
      ext_a_q <= '0; ext_b_q <= '0; outer_q <= '0; inner_q <= '0;
      phase_q <= 1'b0; busy_q <= 1'b0; out_valid_o <= 1'b0;
      r_q <= '0; c_q <= '0; last_q <= 1'b0; rowbase_q <= '0;
      write_valid_o <= 1'b0; done_res_o <= 1'b0;
      pixel_row_o <= '0; pixel_col_o <= '0; byte_address_o <= '0;
      chan0_o <= '0; chan1_o <= '0; chan2_o <= '0;
    end else begin
      if (out_valid_o && !out_stall_i) out_valid_o <= 1'b0;
      unique case (state_q)
        StIdle: begin
          if (in_acc && !op_i) begin
            if (kind_ok) begin
              kind_q <= shape_kind_i; srow_q <= ld_row; scol_q <= ld_col;
              ext_a_q <= ld_a; ext_b_q <= ld_b; outer_q <= '0; inner_q <= '0;
              phase_q <= 1'b0; busy_q <= 1'b1;
            end
          end else if (in_acc && busy_q) begin
            last_q <= 1'b0;
            state_q <= StClip;
            case (kind_q)
              3'(spg_pkg::KindPlus): begin
                if (!phase_q) begin
                  r_q <= 16'(srow_q) + oi - ea; c_q <= 16'(scol_q);
                end else begin
                  r_q <= 16'(srow_q); c_q <= 16'(scol_q) + oi - ea;
                  last_q <= outer_q >= 14'({ext_a_q, 1'b0});
                  outer_q <= outer_q + 14'd1;
                end
                phase_q <= ~phase_q;
              end
              3'(spg_pkg::KindOutline): begin
                if (inner_q == 14'd0) begin
                  r_q <= 16'(srow_q) + oi - ea;
                  c_q <= phase_q ? 16'(scol_q) + eb : 16'(scol_q) - eb;
                  if (phase_q) begin
                    if (outer_q >= 14'({ext_a_q, 1'b0})) begin
                      inner_q <= 14'd1; outer_q <= '0;
                    end else outer_q <= outer_q + 14'd1;
                  end
                end else begin
                  c_q <= 16'(scol_q) + oi - eb;
                  r_q <= phase_q ? 16'(srow_q) + ea : 16'(srow_q) - ea;
                  if (phase_q) begin
                    last_q <= outer_q >= 14'({ext_b_q, 1'b0});
                    outer_q <= outer_q + 14'd1;
                  end
                end
                phase_q <= ~phase_q;
              end
              3'(spg_pkg::KindFilled): begin
                r_q <= 16'(srow_q) + oi - ea;
                c_q <= 16'(scol_q) + ii - eb;
                if (inner_q >= 14'({ext_b_q, 1'b0})) begin
                  last_q <= outer_q >= 14'({ext_a_q, 1'b0});
                  inner_q <= '0; outer_q <= outer_q + 14'd1;
                end else inner_q <= inner_q + 14'd1;
              end
              default: begin
                r_q <= q16(mul_p, srow_q);
                state_q <= StCol;
              end
            endcase
          end
        end
        StCol: begin
          c_q <= q16(mul_p, scol_q);
          last_q <= outer_q >= 14'(spg_pkg::AngleSteps - 1);
          outer_q <= outer_q + 14'd1;
          state_q <= StClip;
        end
        StClip: begin
          rowbase_q <= 26'(mul_p);
          state_q <= StAddr;
        end
        StAddr: begin
          if (last_q) busy_q <= 1'b0;
          write_valid_o <= clip_ok;
          done_res_o <= last_q;
          pixel_row_o <= clip_ok ? r_q[11:0] : 12'd0;
          pixel_col_o <= clip_ok ? c_q[11:0] : 12'd0;
          byte_address_o <= clip_ok ? 26'(rowbase_q * 26'(chans_q) + col_term) : 26'd0;
          chan0_o <= (chans_q > 2'd1) ? pal[23:16] : 8'd0;
          chan1_o <= (chans_q > 2'd1) ? pal[15:8] : 8'd0;
          chan2_o <= (chans_q > 2'd2) ? pal[7:0] : 8'd0;
          out_valid_o <= 1'b1;
          state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/spg_checker.sv
// Port-level checker for the shape pixel generator, bound to the top level.
// Depends on shape_pixel_generator ports only.
`default_nettype none
module spg_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        write_valid_o,
  input logic [11:0] pixel_row_o,
  input logic [25:0] byte_address_o
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(byte_address_o))
    else $error("stalled result changed");
  a_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> in_stall_o)
    else $error("input taken while a result waits");
  a_clip_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !write_valid_o |-> pixel_row_o == 12'd0)
    else $error("clipped pixel has a row");
  a_clip_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !write_valid_o |-> byte_address_o == 26'd0)
    else $error("clipped pixel has an address");
endmodule

bind shape_pixel_generator spg_checker u_spg_checker (
  .clk_i, .rst_ni, .in_stall_o, .out_valid_o, .out_stall_i,
  .write_valid_o, .pixel_row_o, .byte_address_o
);
`default_nettype wire
